[rtl/yuyv_to_planar_420_crop_top_defines.svh]
// Assertion macros for the YUYV to planar 4:2:0 crop block.
// Included by yuyv_to_planar_420_crop_top.sv; no other dependencies.
`ifndef YUYV_TO_PLANAR_420_CROP_TOP_DEFINES_SVH
`define YUYV_TO_PLANAR_420_CROP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define YUYVCROP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define YUYVCROP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/yuyvcrop_pkg.sv]
// Shared constants for the YUYV to planar 4:2:0 crop block.
// No dependencies; used by yuyv_to_planar_420_crop_top.sv.
`timescale 1ns / 1ps
`default_nettype none

package yuyvcrop_pkg;

	// Register field widths
	localparam int SIZE_W  = 11;
	localparam int CNT_W   = 10;
	localparam int LADDR_W = 20;
	localparam int CADDR_W = 21;
	localparam int IDX_W   = 3;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_IN_WIDTH    = 3'd0;
	localparam logic [IDX_W-1:0] REG_IN_HEIGHT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_OUT_WIDTH   = 3'd2;
	localparam logic [IDX_W-1:0] REG_OUT_HEIGHT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_INVERT_ROWS = 3'd4;

	// Register reset values
	localparam logic [SIZE_W-1:0] RST_IN_WIDTH   = 11'd320;
	localparam logic [SIZE_W-1:0] RST_IN_HEIGHT  = 11'd240;
	localparam logic [SIZE_W-1:0] RST_OUT_WIDTH  = 11'd352;
	localparam logic [SIZE_W-1:0] RST_OUT_HEIGHT = 11'd288;

	// Chroma offset-binary to two's complement flip
	localparam logic [7:0] CHROMA_FLIP = 8'h80;

	// Output widths above this use a 16-row vertical pad grid, else 4-row
	localparam logic [SIZE_W-1:0] WIDE_LIMIT = 11'd176;

	// Cycles the geometry registers need after reset or a register write
	localparam logic [2:0] SETTLE_CYCLES = 3'd5;

endpackage

`default_nettype wire

[rtl/yuyv_to_planar_420_crop_top.sv]
// Top level of the YUYV 4:2:2 to planar 4:2:0 converter with centre crop.
// Depends on yuyvcrop_pkg.sv and yuyv_to_planar_420_crop_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packed YUYV word per clock while pix_stall is low and returns,
// for each word inside the centred crop window, one result out of the
// stage 4 register: two luma bytes with their Y plane address and, on the
// first row of each row pair, U and V with their plane addresses. Words
// outside the crop give no result. Throughput is one word per cycle while
// pix_stall is low; a chain of four stage registers (capture, crop test,
// multiply, address add) with per-stage bubble collapse lets new words
// enter while a result waits on res_stall. The frame geometry (crop window,
// pads, plane bases) lives in registers derived from the configuration
// over five levels, so pix_stall is held high after reset and after every
// configuration write until settle_q is zero. cfg_ready is always high.
`include "yuyv_to_planar_420_crop_top_defines.svh"

module yuyv_to_planar_420_crop_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// configuration write channel
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [yuyvcrop_pkg::IDX_W-1:0]          cfg_index,
	input  wire logic [yuyvcrop_pkg::SIZE_W-1:0]         cfg_data,
	// pixel word channel
	input  wire logic                                    pix_valid,
	output logic                                         pix_stall,
	input  wire logic [7:0]                              luma_first,
	input  wire logic [7:0]                              chroma_blue,
	input  wire logic [7:0]                              luma_second,
	input  wire logic [7:0]                              chroma_red,
	input  wire logic                                    frame_start,
	// result channel
	output logic                                         res_valid,
	input  wire logic                                    res_stall,
	output logic [yuyvcrop_pkg::LADDR_W-1:0]             luma_address,
	output logic [7:0]                                   luma_out_first,
	output logic [7:0]                                   luma_out_second,
	output logic                                         chroma_valid,
	output logic [yuyvcrop_pkg::CADDR_W-1:0]             blue_address,
	output logic [7:0]                                   blue_out,
	output logic [yuyvcrop_pkg::CADDR_W-1:0]             red_address,
	output logic [7:0]                                   red_out,
	output logic                                         frame_done
);

	localparam int SW = yuyvcrop_pkg::SIZE_W;
	localparam int CW = yuyvcrop_pkg::CNT_W;
	localparam int LW = yuyvcrop_pkg::LADDR_W;
	localparam int AW = yuyvcrop_pkg::CADDR_W;

	// Configuration registers
	logic [SW-1:0] in_width_q, in_height_q, out_width_q, out_height_q;
	logic          invert_rows_q;
	logic [2:0]    settle_q;
	logic          cfg_write;
	logic [SW-1:0] width_sat, height_sat;

	// Source position counters
	logic [CW-1:0] source_column_q, source_row_q;
	logic [CW-1:0] col_cur, row_cur, col_next;
	logic [CW-1:0] words_per_row;

	// Derived geometry, level by level
	logic [SW-1:0] w_q, h_q;
	logic [AW-1:0] area_q;
	logic          wide_q;
	logic [CW-1:0] top_q, left_q, words_q, outvpad_q;
	logic [SW-1:0] outpad_q;
	logic [AW-1:0] area5_q;
	logic          crop_ok_q;
	logic [SW-1:0] row_last_q, col_end_q, col_last_q;
	logic [AW-1:0] vrow_q;
	logic [18:0]   cvp_q;
	logic [LW-1:0] lbase_q;
	logic [AW-1:0] coff0_q, ubase_q, vbase_q;
	logic [SW-1:0] vdiff;
	logic [CW-1:0] vhalf;

	// Pipeline
	logic          en1, en2, en3, en4, accept;
	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [7:0]    y0_s1, y1_s1, cb_s1, cr_s1;
	logic [CW-1:0] row_s1, col_s1;
	logic [7:0]    y0_s2, y1_s2, cb_s2, cr_s2;
	logic [CW-1:0] d_s2, wc_s2;
	logic          last_s2;
	logic [7:0]    y0_s3, y1_s3, cb_s3, cr_s3;
	logic [CW-1:0] wc_s3;
	logic          cv_s3, last_s3;
	logic [AW-1:0] lmul_s3;
	logic [18:0]   cmul_s3;
	logic          in_window;
	logic [CW-1:0] d_calc;
	logic [AW-1:0] coff_calc;

	// Write handshake: always ready
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;

	// Clip size writes to 11 bits, saturate, force even
	always_comb begin
		width_sat  = cfg_data;
		height_sat = cfg_data;
		if (13'(cfg_data) > 13'(MAX_WIDTH)) begin
			width_sat = SW'(MAX_WIDTH);
		end
		if (13'(cfg_data) > 13'(MAX_HEIGHT)) begin
			height_sat = SW'(MAX_HEIGHT);
		end
		width_sat[0]  = 1'b0;
		height_sat[0] = 1'b0;
	end

	// Register writes; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q    <= yuyvcrop_pkg::RST_IN_WIDTH;
			in_height_q   <= yuyvcrop_pkg::RST_IN_HEIGHT;
			out_width_q   <= yuyvcrop_pkg::RST_OUT_WIDTH;
			out_height_q  <= yuyvcrop_pkg::RST_OUT_HEIGHT;
			invert_rows_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				yuyvcrop_pkg::REG_IN_WIDTH:    in_width_q    <= width_sat;
				yuyvcrop_pkg::REG_IN_HEIGHT:   in_height_q   <= height_sat;
				yuyvcrop_pkg::REG_OUT_WIDTH:   out_width_q   <= width_sat;
				yuyvcrop_pkg::REG_OUT_HEIGHT:  out_height_q  <= height_sat;
				yuyvcrop_pkg::REG_INVERT_ROWS: invert_rows_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Hold off input while the geometry registers settle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= yuyvcrop_pkg::SETTLE_CYCLES;
		end else if (cfg_write) begin
			settle_q <= yuyvcrop_pkg::SETTLE_CYCLES;
		end else if (settle_q != 3'd0) begin
			settle_q <= settle_q - 3'd1;
		end
	end

	// Geometry level 1: crop size, luma plane area
	assign vdiff = out_height_q - h_q;
	assign vhalf = vdiff[SW-1:1];
	always_ff @(posedge clk) begin
		w_q    <= (in_width_q < out_width_q) ? in_width_q : out_width_q;
		h_q    <= (in_height_q < out_height_q) ? in_height_q : out_height_q;
		area_q <= AW'(out_width_q * out_height_q);
		wide_q <= out_width_q > yuyvcrop_pkg::WIDE_LIMIT;
	end

	// Geometry level 2: crop origin, pads, V plane scale
	always_ff @(posedge clk) begin
		top_q     <= CW'((in_height_q - h_q) >> 1);
		left_q    <= CW'((in_width_q - w_q) >> 2);
		words_q   <= w_q[SW-1:1];
		outpad_q  <= out_width_q - w_q;
		outvpad_q <= wide_q ? {vhalf[CW-1:4], 4'b0000} : {vhalf[CW-1:2], 2'b00};
		area5_q   <= area_q + (area_q >> 2);
		crop_ok_q <= (h_q != '0) && (w_q != '0);
	end

	// Geometry level 3: window bounds, pad products
	always_ff @(posedge clk) begin
		row_last_q <= SW'(top_q) + h_q - SW'(1);
		col_end_q  <= SW'(left_q) + SW'(words_q);
		vrow_q     <= AW'(outvpad_q) * AW'(out_width_q);
		cvp_q      <= 19'(out_width_q[SW-1:2]) * 19'(outvpad_q);
	end

	// Geometry level 4: luma base, chroma offset
	always_ff @(posedge clk) begin
		lbase_q    <= LW'(vrow_q) + LW'(outpad_q[SW-1:1]);
		coff0_q    <= AW'(cvp_q) + AW'(outpad_q[SW-1:2]);
		col_last_q <= col_end_q - SW'(1);
	end

	// Geometry level 5: U and V plane bases
	always_ff @(posedge clk) begin
		ubase_q <= area_q + coff0_q;
		vbase_q <= area5_q + coff0_q;
	end

	// Stage enables: a stage loads when empty or when the next one loads
	assign en4       = !vld_s4 || !res_stall;
	assign en3       = !vld_s3 || en4;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign pix_stall = !en1 || (settle_q != 3'd0);
	assign accept    = pix_valid && !pix_stall;

	// Source position of this word and the next
	assign col_cur       = frame_start ? '0 : source_column_q;
	assign row_cur       = frame_start ? '0 : source_row_q;
	assign col_next      = col_cur + CW'(1);
	assign words_per_row = in_width_q[SW-1:1];

	// Advance column and row counters per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_column_q <= '0;
			source_row_q    <= '0;
		end else if (accept) begin
			if (col_next >= words_per_row || col_next == '0) begin
				source_column_q <= '0;
				source_row_q    <= row_cur + CW'(1);
			end else begin
				source_column_q <= col_next;
				source_row_q    <= row_cur;
			end
		end
	end

	// Crop window test and destination row
	assign in_window = crop_ok_q
		&& (row_s1 >= top_q) && (SW'(row_s1) <= row_last_q)
		&& (col_s1 >= left_q) && (SW'(col_s1) < col_end_q);
	assign d_calc = invert_rows_q ? (row_last_q[CW-1:0] - row_s1) : (row_s1 - top_q);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= accept;
			end
			if (en2) begin
				vld_s2 <= vld_s1 && in_window;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
			if (en4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// Stage 1: capture the word and its position
	always_ff @(posedge clk) begin
		if (accept) begin
			y0_s1  <= luma_first;
			y1_s1  <= luma_second;
			cb_s1  <= chroma_blue;
			cr_s1  <= chroma_red;
			row_s1 <= row_cur;
			col_s1 <= col_cur;
		end
	end

	// Stage 2: crop-relative row and word, end of frame
	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			y0_s2   <= y0_s1;
			y1_s2   <= y1_s1;
			cb_s2   <= cb_s1;
			cr_s2   <= cr_s1;
			d_s2    <= d_calc;
			wc_s2   <= col_s1 - left_q;
			last_s2 <= (SW'(row_s1) == row_last_q) && (SW'(col_s1) == col_last_q);
		end
	end

	// Stage 3: row offsets into luma and chroma planes, chroma sign flip
	always_ff @(posedge clk) begin
		if (en3 && vld_s2) begin
			y0_s3   <= y0_s2;
			y1_s3   <= y1_s2;
			cb_s3   <= cb_s2 ^ yuyvcrop_pkg::CHROMA_FLIP;
			cr_s3   <= cr_s2 ^ yuyvcrop_pkg::CHROMA_FLIP;
			wc_s3   <= wc_s2;
			cv_s3   <= !d_s2[0];
			last_s3 <= last_s2;
			lmul_s3 <= AW'(d_s2) * AW'(out_width_q);
			cmul_s3 <= 19'(d_s2[CW-1:1]) * 19'(out_width_q[SW-1:1]);
		end
	end

	// Stage 4: final addresses into the result register
	assign coff_calc = AW'(cmul_s3) + AW'(wc_s3);
	always_ff @(posedge clk) begin
		if (en4 && vld_s3) begin
			luma_address    <= lbase_q + LW'(lmul_s3) + LW'({wc_s3, 1'b0});
			luma_out_first  <= y0_s3;
			luma_out_second <= y1_s3;
			chroma_valid    <= cv_s3;
			blue_address    <= cv_s3 ? (ubase_q + coff_calc) : '0;
			blue_out        <= cv_s3 ? cb_s3 : 8'h00;
			red_address     <= cv_s3 ? (vbase_q + coff_calc) : '0;
			red_out         <= cv_s3 ? cr_s3 : 8'h00;
			frame_done      <= last_s3;
		end
	end

	assign res_valid = vld_s4;

	// Checks
	`YUYVCROP_ASSERT_IMPL(a_settle_blocks, clk, arst_n, settle_q != 3'd0, pix_stall, "word taken while geometry settles")
	`YUYVCROP_ASSERT_IMPL(a_chroma_zero, clk, arst_n, res_valid && !chroma_valid, blue_address == '0 && red_address == '0 && blue_out == 8'h00 && red_out == 8'h00, "chroma fields set on luma-only row")
	`YUYVCROP_ASSERT_NEXT(a_result_source, clk, arst_n, !vld_s3 && !(vld_s4 && res_stall), !res_valid, "result appeared without a stage 3 item")

endmodule

`default_nettype wire
